>>> design/modbus_rtu_client_framer_assert.svh
// Assertion macros for the Modbus RTU client framer.
`ifndef MODBUS_RTU_CLIENT_FRAMER_ASSERT_SVH
`define MODBUS_RTU_CLIENT_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define MRCF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mrcf assertion failed");

`define MRCF_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mrcf forbidden condition");

`else

`define MRCF_ASSERT(label, clk, rst_n, prop)

`define MRCF_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> design/mrcf_pkg.sv
// Shared types, codes and functions of the Modbus RTU client framer.
package mrcf_pkg;

  localparam int unsigned PLEN_W = 6;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD = 2'd1;
  localparam logic [1:0] REQ_RX      = 2'd2;

  localparam logic [7:0] FC_RD_COILS    = 8'd1;
  localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
  localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT    = 8'd4;
  localparam logic [7:0] FC_WR_COIL     = 8'd5;
  localparam logic [7:0] FC_WR_REG      = 8'd6;
  localparam logic [7:0] FC_WR_COILS    = 8'd15;
  localparam logic [7:0] FC_WR_REGS     = 8'd16;

  localparam logic OUT_KIND_TX      = 1'b0;
  localparam logic OUT_KIND_VERDICT = 1'b1;

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_COUNT    = 3'd1;
  localparam logic [2:0] VERDICT_CRC      = 3'd2;
  localparam logic [2:0] VERDICT_ECHO     = 3'd3;
  localparam logic [2:0] VERDICT_UNKNOWN  = 3'd4;
  localparam logic [2:0] VERDICT_SHORT    = 3'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_JUDGE
  } ctrl_state_e;

  typedef struct packed {
    logic take_start;
    logic take_pay;
    logic take_rx;
    logic tx_init;
    logic emit;
    logic judge;
  } cmd_t;

  typedef struct packed {
    logic req_start;
    logic req_pay;
    logic req_rx;
    logic rx_last;
    logic start_sends;
    logic pay_ok;
    logic pay_done;
    logic tx_final;
    logic out_free;
  } status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] calc_expected(input logic [7:0] fc, input logic [15:0] q);
    logic [17:0] l;
    logic [7:0]  res;
    l   = '0;
    res = '0;
    case (fc)
      FC_RD_COILS, FC_RD_DISCRETE: begin
        l   = 18'd5 + ((18'(q) + 18'd7) >> 3);
        res = (l > 18'd255) ? 8'hFF : l[7:0];
      end
      FC_RD_HOLDING, FC_RD_INPUT: begin
        l   = 18'd5 + {1'b0, q, 1'b0};
        res = (l > 18'd255) ? 8'hFF : l[7:0];
      end
      FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: begin
        res = 8'd8;
      end
      default: begin
        res = 8'd0;
      end
    endcase
    return res;
  endfunction

endpackage

>>> design/mrcf_req_if.sv
// Request channel: start items, payload bytes and received bytes.
interface mrcf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  func_code;
  logic [15:0] first_addr;
  logic [15:0] quantity;
  logic [5:0]  payload_len;
  logic [7:0]  data_byte;
  logic        rx_last;

  modport source (
    output valid, req_type, func_code, first_addr, quantity, payload_len, data_byte,
    output rx_last,
    input  ready
  );

  modport sink (
    input  valid, req_type, func_code, first_addr, quantity, payload_len, data_byte,
    input  rx_last,
    output ready
  );
endinterface

>>> design/mrcf_rsp_if.sv
// Result channel: transmit bytes and response verdicts.
interface mrcf_rsp_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [2:0] verdict;

  modport source (
    output valid, out_kind, tx_byte, tx_last, verdict,
    input  ready
  );

  modport sink (
    input  valid, out_kind, tx_byte, tx_last, verdict,
    output ready
  );
endinterface

>>> design/mrcf_ctrl.sv
// Controller state machine: accepts items, sequences frame emission and verdicts.
module mrcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mrcf_pkg::status_t st_i,
  output mrcf_pkg::cmd_t    cmd_o
);

  mrcf_pkg::ctrl_state_e state_q, state_d;
  logic                  acc;

  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mrcf_pkg::ST_IDLE: begin
        if (cmd_o.tx_init) begin
          state_d = mrcf_pkg::ST_FETCH;
        end else if (cmd_o.take_rx && st_i.rx_last) begin
          state_d = mrcf_pkg::ST_JUDGE;
        end
      end
      mrcf_pkg::ST_FETCH: begin
        state_d = mrcf_pkg::ST_EMIT;
      end
      mrcf_pkg::ST_EMIT: begin
        if (st_i.out_free) begin
          state_d = st_i.tx_final ? mrcf_pkg::ST_IDLE : mrcf_pkg::ST_FETCH;
        end
      end
      mrcf_pkg::ST_JUDGE: begin
        if (st_i.out_free) begin
          state_d = mrcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mrcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == mrcf_pkg::ST_IDLE);
    cmd_o            = '0;
    cmd_o.take_start = acc && st_i.req_start;
    cmd_o.take_pay   = acc && st_i.req_pay && st_i.pay_ok;
    cmd_o.take_rx    = acc && st_i.req_rx;
    cmd_o.tx_init    = (cmd_o.take_start && st_i.start_sends) ||
                       (cmd_o.take_pay && st_i.pay_done);
    cmd_o.emit       = (state_q == mrcf_pkg::ST_EMIT) && st_i.out_free;
    cmd_o.judge      = (state_q == mrcf_pkg::ST_JUDGE) && st_i.out_free;
  end

endmodule

>>> design/mrcf_dp.sv
// Datapath: request header, payload memory, transmit CRC, receive checker, output register.
module mrcf_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        func_code_i,
  input  logic [15:0]       first_addr_i,
  input  logic [15:0]       quantity_i,
  input  logic [5:0]        payload_len_i,
  input  logic [7:0]        data_byte_i,
  input  logic              rx_last_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_kind_o,
  output logic [7:0]        tx_byte_o,
  output logic              tx_last_o,
  output logic [2:0]        verdict_o,
  input  mrcf_pkg::cmd_t    cmd_i,
  output mrcf_pkg::status_t st_o
);

  localparam int unsigned PW    = mrcf_pkg::PLEN_W;
  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + 9);

  logic [7:0]       slave_addr_q;
  logic [7:0]       echo_q [6];
  logic [7:0]       echo_in [6];
  logic [7:0]       exp_len_q;
  logic [PW-1:0]    plen_q;
  logic [PW-1:0]    filled_q;
  logic             pending_q;
  logic             is_multi_in;
  logic [PW-1:0]    plen_sat;

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rdata_q;
  logic [IDX_W-1:0] rd_off;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] body_len_q;
  logic [15:0]      tx_crc_q;
  logic [7:0]       tx_sel;

  logic [15:0]      rx_crc_q;
  logic [7:0]       rx_count_q;
  logic [7:0]       rx_func_q;
  logic [7:0]       rx_bc_q;
  logic             echo_bad_q;
  logic [2:0]       verdict;

  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  assign is_multi_in = (func_code_i == mrcf_pkg::FC_WR_COILS) ||
                       (func_code_i == mrcf_pkg::FC_WR_REGS);
  assign plen_sat    = (payload_len_i > PW'(MAX_PAYLOAD)) ? PW'(MAX_PAYLOAD) : payload_len_i;

  always_comb begin
    echo_in[0] = slave_addr_q;
    echo_in[1] = func_code_i;
    echo_in[2] = first_addr_i[15:8];
    echo_in[3] = first_addr_i[7:0];
    echo_in[4] = quantity_i[15:8];
    echo_in[5] = quantity_i[7:0];
    if (func_code_i == mrcf_pkg::FC_WR_COIL) begin
      echo_in[4] = (quantity_i == 16'd1) ? 8'hFF : 8'h00;
      echo_in[5] = 8'h00;
    end else if (!(func_code_i inside {[mrcf_pkg::FC_RD_COILS:mrcf_pkg::FC_WR_REG],
                                       mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS})) begin
      for (int i = 0; i < 6; i++) begin
        echo_in[i] = 8'(i);
      end
    end
  end

  // request header and payload collection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        echo_q[i] <= 8'h00;
      end
      exp_len_q  <= '0;
      plen_q     <= '0;
      filled_q   <= '0;
      pending_q  <= 1'b0;
      body_len_q <= '0;
    end else if (cmd_i.take_start) begin
      echo_q     <= echo_in;
      exp_len_q  <= mrcf_pkg::calc_expected(func_code_i, quantity_i);
      plen_q     <= plen_sat;
      filled_q   <= '0;
      pending_q  <= is_multi_in && (plen_sat != '0);
      body_len_q <= is_multi_in ? (IDX_W'(7) + IDX_W'(plen_sat)) : IDX_W'(6);
    end else if (cmd_i.take_pay) begin
      filled_q <= filled_q + PW'(1);
      if (st_o.pay_done) begin
        pending_q <= 1'b0;
      end
    end
  end

  assign wr_addr = filled_q[AW-1:0];
  assign rd_off  = idx_q - IDX_W'(7);
  assign rd_addr = rd_off[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pay) begin
      mem[wr_addr] <= data_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    if (idx_q < body_len_q) begin
      if (idx_q < IDX_W'(6)) begin
        tx_sel = echo_q[idx_q[2:0]];
      end else if (idx_q == IDX_W'(6)) begin
        tx_sel = 8'(plen_q);
      end else begin
        tx_sel = rdata_q;
      end
    end else if (idx_q == body_len_q) begin
      tx_sel = tx_crc_q[7:0];
    end else begin
      tx_sel = tx_crc_q[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      tx_crc_q <= mrcf_pkg::CRC_INIT;
    end else if (cmd_i.tx_init) begin
      idx_q    <= '0;
      tx_crc_q <= mrcf_pkg::CRC_INIT;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + IDX_W'(1);
      if (idx_q < body_len_q) begin
        tx_crc_q <= mrcf_pkg::crc16_byte(tx_crc_q, tx_sel);
      end
    end
  end

  // receive checker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_crc_q   <= mrcf_pkg::CRC_INIT;
      rx_count_q <= '0;
      rx_func_q  <= '0;
      rx_bc_q    <= '0;
      echo_bad_q <= 1'b0;
    end else if (cmd_i.take_start || cmd_i.judge) begin
      rx_crc_q   <= mrcf_pkg::CRC_INIT;
      rx_count_q <= '0;
      rx_func_q  <= '0;
      rx_bc_q    <= '0;
      echo_bad_q <= 1'b0;
    end else if (cmd_i.take_rx) begin
      if ((rx_count_q < 8'd6) && (data_byte_i != echo_q[rx_count_q[2:0]])) begin
        echo_bad_q <= 1'b1;
      end
      if (rx_count_q == 8'd1) begin
        rx_func_q <= data_byte_i;
      end
      if (rx_count_q == 8'd2) begin
        rx_bc_q <= data_byte_i;
      end
      rx_crc_q <= mrcf_pkg::crc16_byte(rx_crc_q, data_byte_i);
      if (rx_count_q != 8'hFF) begin
        rx_count_q <= rx_count_q + 8'd1;
      end
    end
  end

  always_comb begin
    case (rx_func_q)
      mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE,
      mrcf_pkg::FC_RD_HOLDING, mrcf_pkg::FC_RD_INPUT: begin
        if (rx_count_q < 8'd3) begin
          verdict = mrcf_pkg::VERDICT_SHORT;
        end else if (rx_bc_q != (exp_len_q - 8'd5)) begin
          verdict = mrcf_pkg::VERDICT_COUNT;
        end else if (rx_count_q != exp_len_q) begin
          verdict = mrcf_pkg::VERDICT_SHORT;
        end else if (rx_crc_q != 16'h0000) begin
          verdict = mrcf_pkg::VERDICT_CRC;
        end else begin
          verdict = mrcf_pkg::VERDICT_OK;
        end
      end
      mrcf_pkg::FC_WR_COIL, mrcf_pkg::FC_WR_REG,
      mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS: begin
        if (rx_count_q < 8'd8) begin
          verdict = mrcf_pkg::VERDICT_SHORT;
        end else if (echo_bad_q) begin
          verdict = mrcf_pkg::VERDICT_ECHO;
        end else if (rx_crc_q != 16'h0000) begin
          verdict = mrcf_pkg::VERDICT_CRC;
        end else begin
          verdict = mrcf_pkg::VERDICT_OK;
        end
      end
      default: begin
        verdict = mrcf_pkg::VERDICT_UNKNOWN;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.judge) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o <= mrcf_pkg::OUT_KIND_TX;
      tx_byte_o  <= tx_sel;
      tx_last_o  <= st_o.tx_final;
      verdict_o  <= mrcf_pkg::VERDICT_OK;
    end else if (cmd_i.judge) begin
      out_kind_o <= mrcf_pkg::OUT_KIND_VERDICT;
      tx_byte_o  <= 8'h00;
      tx_last_o  <= 1'b0;
      verdict_o  <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    st_o.req_start   = (req_type_i == mrcf_pkg::REQ_START);
    st_o.req_pay     = (req_type_i == mrcf_pkg::REQ_PAYLOAD);
    st_o.req_rx      = (req_type_i == mrcf_pkg::REQ_RX);
    st_o.rx_last     = rx_last_i;
    st_o.start_sends = !(is_multi_in && (plen_sat != '0));
    st_o.pay_ok      = pending_q && (filled_q < PW'(MAX_PAYLOAD));
    st_o.pay_done    = ({1'b0, filled_q} + (PW + 1)'(1)) >= {1'b0, plen_q};
    st_o.tx_final    = (idx_q == (body_len_q + IDX_W'(1)));
    st_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

>>> design/modbus_rtu_client_framer.sv
// Top level of the Modbus RTU client framer: request framing and response checking.
//
//   channel   dir  handshake      carries
//   req_i     in   valid/ready    start, payload byte or received byte
//   rsp_o     out  valid/ready    transmit byte or verdict
//   cfg       in   cfg_we_i       slave_address
//
// Payload and received bytes are taken while idle; a received last byte leads
// to the judge state. Each byte is sent via a fetch state (payload memory read)
// and an emit state (output register); a frame has 8 bytes, or 9 + payload_len.
// No input is taken while a frame or verdict is in progress; emission stalls
// while rsp_o is not ready. Reset needs no clearing pass.
`include "modbus_rtu_client_framer_assert.svh"

module modbus_rtu_client_framer #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  mrcf_req_if.sink   req_i,
  mrcf_rsp_if.source rsp_o
);

  mrcf_pkg::cmd_t    cmd;
  mrcf_pkg::status_t st;
  logic              in_ready;

  assign req_i.ready = in_ready;

  mrcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mrcf_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_i.req_type),
    .func_code_i     (req_i.func_code),
    .first_addr_i    (req_i.first_addr),
    .quantity_i      (req_i.quantity),
    .payload_len_i   (req_i.payload_len),
    .data_byte_i     (req_i.data_byte),
    .rx_last_i       (req_i.rx_last),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_kind_o      (rsp_o.out_kind),
    .tx_byte_o       (rsp_o.tx_byte),
    .tx_last_o       (rsp_o.tx_last),
    .verdict_o       (rsp_o.verdict),
    .cmd_i           (cmd),
    .st_o            (st)
  );

  `MRCF_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.take_start, cmd.take_pay, cmd.take_rx, cmd.emit, cmd.judge}))
  `MRCF_ASSERT(a_idle_after_frame, clk_i, rst_ni, (cmd.emit && st.tx_final) |=> in_ready)
  `MRCF_ASSERT(a_verdict_loaded, clk_i, rst_ni, cmd.judge |=> (rsp_o.valid && rsp_o.out_kind))
  `MRCF_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, in_ready && (cmd.emit || cmd.judge))

endmodule

>>> tb/modbus_rtu_client_framer_test.sv
// Self-checking testbench of the Modbus RTU client framer: request frames and reply verdicts.
`timescale 1ns / 100ps

module modbus_rtu_client_framer_test;

  localparam int          PAYLOAD_MAX = 32;
  localparam logic  [1:0] REQ_UNUSED  = 2'd3;
  localparam int          SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [5:0]  plen;
    logic [7:0]  data;
    logic        last;
  } req_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic       last;
    logic [2:0] verdict;
  } frame_out_t;

  typedef struct packed {
    req_item_t  it;
    logic       pinned;
    logic [2:0] verdict;
  } script_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  mrcf_req_if req ();
  mrcf_rsp_if rsp ();

  modbus_rtu_client_framer #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // framer state as the block should hold it
  logic [7:0]  slave_addr;
  logic [7:0]  held_fc;
  logic [7:0]  want_len;
  logic [7:0]  pay_mem [0:PAYLOAD_MAX-1];
  int          pay_count;
  int          pay_target;
  bit          pay_open;
  logic [7:0]  echo [0:5];
  logic [15:0] rx_crc;
  int          rx_n;
  logic [7:0]  rx_fc;
  logic [7:0]  rx_bc;
  bit          echo_bad;
  logic [7:0]  frame_buf [0:PAYLOAD_MAX+8];

  frame_out_t  due_out [$];

  int src_idle;
  int sink_idle;
  int stall_left;
  int items_sent;
  int mismatches;
  int tx_seen;
  int verdict_seen [0:7];

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ mrcf_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [7:0] reply_length(input logic [7:0] fc, input logic [15:0] q);
    int l;
    case (fc)
      mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE: l = 5 + ((int'(q) + 7) >> 3);
      mrcf_pkg::FC_RD_HOLDING, mrcf_pkg::FC_RD_INPUT:  l = 5 + 2 * int'(q);
      mrcf_pkg::FC_WR_COIL, mrcf_pkg::FC_WR_REG,
      mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS:     l = 8;
      default: l = 0;
    endcase
    return (l > 255) ? 8'hFF : 8'(l);
  endfunction

  function automatic logic [2:0] judge_reply();
    case (rx_fc)
      mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE,
      mrcf_pkg::FC_RD_HOLDING, mrcf_pkg::FC_RD_INPUT: begin
        if (rx_n < 3) return mrcf_pkg::VERDICT_SHORT;
        if (rx_bc != 8'(want_len - 8'd5)) return mrcf_pkg::VERDICT_COUNT;
        if (rx_n != int'(want_len)) return mrcf_pkg::VERDICT_SHORT;
        if (rx_crc != 16'h0000) return mrcf_pkg::VERDICT_CRC;
        return mrcf_pkg::VERDICT_OK;
      end
      mrcf_pkg::FC_WR_COIL, mrcf_pkg::FC_WR_REG,
      mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS: begin
        if (rx_n < 8) return mrcf_pkg::VERDICT_SHORT;
        if (echo_bad) return mrcf_pkg::VERDICT_ECHO;
        if (rx_crc != 16'h0000) return mrcf_pkg::VERDICT_CRC;
        return mrcf_pkg::VERDICT_OK;
      end
      default: return mrcf_pkg::VERDICT_UNKNOWN;
    endcase
  endfunction

  function automatic void rx_restart();
    rx_crc   = mrcf_pkg::CRC_INIT;
    rx_n     = 0;
    rx_fc    = 8'h00;
    rx_bc    = 8'h00;
    echo_bad = 1'b0;
  endfunction

  // appends the CRC to frame_buf[0:len-1] and queues every byte
  function automatic void queue_frame(input int len);
    logic [15:0] c;
    frame_out_t o;
    c = mrcf_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) c = crc_step(c, frame_buf[i]);
    frame_buf[len]     = c[7:0];
    frame_buf[len + 1] = c[15:8];
    for (int i = 0; i < len + 2; i++) begin
      o.kind    = mrcf_pkg::OUT_KIND_TX;
      o.tx      = frame_buf[i];
      o.last    = (i == len + 1);
      o.verdict = mrcf_pkg::VERDICT_OK;
      due_out.push_back(o);
    end
  endfunction

  function automatic void queue_multi_write();
    for (int i = 0; i < 6; i++) frame_buf[i] = echo[i];
    frame_buf[6] = 8'(pay_target);
    for (int i = 0; i < pay_target; i++) frame_buf[7 + i] = pay_mem[i];
    pay_open = 1'b0;
    queue_frame(7 + pay_target);
  endfunction

  // returns 1 when the item is not simply dropped by the block
  function automatic bit frame_and_judge(input req_item_t it);
    frame_out_t o;
    case (it.rtype)
      mrcf_pkg::REQ_START: begin
        held_fc   = it.fc;
        want_len  = reply_length(it.fc, it.qty);
        pay_open  = 1'b0;
        pay_count = 0;
        rx_restart();
        frame_buf[0] = slave_addr;
        frame_buf[1] = it.fc;
        frame_buf[2] = it.addr[15:8];
        frame_buf[3] = it.addr[7:0];
        frame_buf[4] = it.qty[15:8];
        frame_buf[5] = it.qty[7:0];
        if (it.fc == mrcf_pkg::FC_WR_COIL) begin
          frame_buf[4] = (it.qty == 16'd1) ? 8'hFF : 8'h00;
          frame_buf[5] = 8'h00;
        end else if (it.fc == mrcf_pkg::FC_WR_COILS || it.fc == mrcf_pkg::FC_WR_REGS) begin
          pay_target = (it.plen > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(it.plen);
          for (int i = 0; i < 6; i++) echo[i] = frame_buf[i];
          if (pay_target == 0) queue_multi_write();
          else pay_open = 1'b1;
          return 1'b1;
        end else if (it.fc < mrcf_pkg::FC_RD_COILS || it.fc > mrcf_pkg::FC_WR_REG) begin
          for (int i = 0; i < 6; i++) frame_buf[i] = 8'(i);
        end
        for (int i = 0; i < 6; i++) echo[i] = frame_buf[i];
        queue_frame(6);
        return 1'b1;
      end
      mrcf_pkg::REQ_PAYLOAD: begin
        if (!pay_open || pay_count >= PAYLOAD_MAX) return 1'b0;
        pay_mem[pay_count] = it.data;
        pay_count++;
        if (pay_count >= pay_target) queue_multi_write();
        return 1'b1;
      end
      mrcf_pkg::REQ_RX: begin
        if (rx_n < 6 && it.data != echo[rx_n]) echo_bad = 1'b1;
        if (rx_n == 1) rx_fc = it.data;
        if (rx_n == 2) rx_bc = it.data;
        rx_crc = crc_step(rx_crc, it.data);
        if (rx_n < 255) rx_n++;
        if (it.last) begin
          o.kind    = mrcf_pkg::OUT_KIND_VERDICT;
          o.tx      = 8'h00;
          o.last    = 1'b0;
          o.verdict = judge_reply();
          due_out.push_back(o);
          rx_restart();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic req_item_t make_item(input logic [1:0] rtype, input logic [7:0] fc,
                                          input logic [15:0] addr, input logic [15:0] qty,
                                          input logic [5:0] plen, input logic [7:0] data,
                                          input logic last);
    req_item_t it;
    it.rtype = rtype;
    it.fc    = fc;
    it.addr  = addr;
    it.qty   = qty;
    it.plen  = plen;
    it.data  = data;
    it.last  = last;
    return it;
  endfunction

  function automatic script_row_t make_row(input logic [1:0] rtype, input logic [7:0] fc,
                                           input logic [15:0] addr, input logic [15:0] qty,
                                           input logic [5:0] plen, input logic [7:0] data,
                                           input logic last, input logic pinned,
                                           input logic [2:0] verdict);
    script_row_t r;
    r.it      = make_item(rtype, fc, addr, qty, plen, data, last);
    r.pinned  = pinned;
    r.verdict = verdict;
    return r;
  endfunction

  task automatic offer(input req_item_t it, input logic pinned, input logic [2:0] pinned_v);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid       = 1'b1;
    req.req_type    = it.rtype;
    req.func_code   = it.fc;
    req.first_addr  = it.addr;
    req.quantity    = it.qty;
    req.payload_len = it.plen;
    req.data_byte   = it.data;
    req.rx_last     = it.last;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    if (frame_and_judge(it)) items_sent++;
    if (pinned) due_out[due_out.size() - 1].verdict = pinned_v;
  endtask

  task automatic send_rx(input logic [7:0] b, input logic last);
    offer(make_item(mrcf_pkg::REQ_RX, 8'($urandom), 16'($urandom), 16'($urandom),
                    6'($urandom), b, last), 1'b0, mrcf_pkg::VERDICT_OK);
  endtask

  task automatic offer_noise();
    offer(make_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 16'($urandom),
                    6'($urandom), 8'($urandom), $urandom_range(0, 3) == 0), 1'b0,
          mrcf_pkg::VERDICT_OK);
  endtask

  // builds a reply to the open request, spoiled on request
  task automatic answer(input bit spoil);
    logic [7:0]  rb [0:63];
    logic [15:0] c;
    int n;
    case (held_fc)
      mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE,
      mrcf_pkg::FC_RD_HOLDING, mrcf_pkg::FC_RD_INPUT: begin
        if (want_len >= 8'd5 && want_len <= 8'd60) begin
          n = want_len - 2;
          rb[0] = slave_addr;
          rb[1] = held_fc;
          rb[2] = want_len - 8'd5;
          for (int i = 3; i < n; i++) rb[i] = 8'($urandom);
        end else begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) rb[i] = 8'($urandom);
        end
      end
      mrcf_pkg::FC_WR_COIL, mrcf_pkg::FC_WR_REG,
      mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS: begin
        n = 6;
        for (int i = 0; i < 6; i++) rb[i] = echo[i];
      end
      default: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) rb[i] = 8'($urandom);
        if (n > 1 && $urandom_range(1) == 1) rb[1] = held_fc | 8'h80;
      end
    endcase
    c = mrcf_pkg::CRC_INIT;
    for (int i = 0; i < n; i++) c = crc_step(c, rb[i]);
    rb[n]     = c[7:0];
    rb[n + 1] = c[15:8];
    n += 2;
    if (spoil) begin
      case ($urandom_range(0, 4))
        0: rb[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
        1: n--;
        2: rb[2] = rb[2] + 8'($urandom_range(1, 255));
        3: begin
          rb[n] = 8'($urandom);
          n++;
        end
        default: n = $urandom_range(1, n - 1);
      endcase
    end
    for (int i = 0; i < n; i++) send_rx(rb[i], i == n - 1);
  endtask

  task automatic run_transfer_sequence();
    logic [7:0]  fc;
    logic [15:0] qty;
    logic [5:0]  plen;
    int          sent;
    int          pick;
    logic [7:0]  codes [0:7];
    codes = '{mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE, mrcf_pkg::FC_RD_HOLDING,
              mrcf_pkg::FC_RD_INPUT, mrcf_pkg::FC_WR_COIL, mrcf_pkg::FC_WR_REG,
              mrcf_pkg::FC_WR_COILS, mrcf_pkg::FC_WR_REGS};
    fc = ($urandom_range(9) == 0) ? 8'($urandom) : codes[$urandom_range(0, 7)];
    case (fc)
      mrcf_pkg::FC_RD_COILS, mrcf_pkg::FC_RD_DISCRETE: qty = 16'($urandom_range(0, 400));
      mrcf_pkg::FC_RD_HOLDING, mrcf_pkg::FC_RD_INPUT:  qty = 16'($urandom_range(0, 27));
      mrcf_pkg::FC_WR_COIL:                            qty = 16'($urandom_range(0, 2));
      default:                                         qty = 16'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 15) plen = 6'd0;
    else if (pick < 30) plen = 6'($urandom_range(PAYLOAD_MAX + 1, 63));
    else plen = 6'($urandom_range(1, 6));
    offer(make_item(mrcf_pkg::REQ_START, fc, 16'($urandom), qty, plen, 8'($urandom),
                    1'($urandom)), 1'b0, mrcf_pkg::VERDICT_OK);
    if (pay_open) begin
      sent = ($urandom_range(99) < 15) ? $urandom_range(0, pay_target - 1) : pay_target;
      for (int i = 0; i < sent; i++) begin
        offer(make_item(mrcf_pkg::REQ_PAYLOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                        6'($urandom), 8'($urandom), 1'($urandom)), 1'b0,
              mrcf_pkg::VERDICT_OK);
      end
    end
    answer($urandom_range(99) < 30);
  endtask

  // 258-byte read reply whose count saturates at the expected 255
  task automatic run_long_reply();
    logic [7:0]  b;
    logic [15:0] c;
    offer(make_item(mrcf_pkg::REQ_START, mrcf_pkg::FC_RD_HOLDING, 16'($urandom), 16'd125,
                    6'd0, 8'h00, 1'b0), 1'b0, mrcf_pkg::VERDICT_OK);
    c = mrcf_pkg::CRC_INIT;
    for (int i = 0; i < 256; i++) begin
      b = (i == 0) ? slave_addr : (i == 1) ? mrcf_pkg::FC_RD_HOLDING :
          (i == 2) ? 8'd250 : 8'($urandom);
      c = crc_step(c, b);
      send_rx(b, 1'b0);
    end
    send_rx(c[7:0], 1'b0);
    send_rx(c[15:8], 1'b1);
  endtask

  task automatic drain(input int extra);
    @(negedge clk_i);
    req.valid = 1'b0;
    while (due_out.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_slave(input logic [7:0] v);
    drain(40);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    slave_addr = v;
  endtask

  task automatic run_phase(input int goal);
    while (items_sent < goal) begin
      if ($urandom_range(99) < 75) run_transfer_sequence();
      else repeat ($urandom_range(1, 6)) offer_noise();
    end
  endtask

  task automatic report(input string what, input frame_out_t want, input frame_out_t got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) begin
      $display("%t %s: expected kind %0d byte %h last %0d verdict %0d,",
               $realtime, what, want.kind, want.tx, want.last, want.verdict);
      $display("    got kind %0d byte %h last %0d verdict %0d",
               got.kind, got.tx, got.last, got.verdict);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else begin
        rsp.ready = ($urandom_range(99) >= sink_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    frame_out_t got;
    frame_out_t want;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = {rsp.out_kind, rsp.tx_byte, rsp.tx_last, rsp.verdict};
      if (due_out.size() == 0) begin
        report("unexpected transfer", '0, got);
      end else begin
        want = due_out.pop_front();
        if (got.kind !== want.kind || got.tx !== want.tx || got.last !== want.last ||
            got.verdict !== want.verdict) begin
          report("mismatch", want, got);
        end else if (want.kind == mrcf_pkg::OUT_KIND_TX) begin
          tx_seen++;
        end else begin
          verdict_seen[want.verdict]++;
        end
      end
    end
  end

  initial begin
    script_row_t script [$];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'h00;
    req.valid       = 1'b0;
    req.req_type    = mrcf_pkg::REQ_START;
    req.func_code   = 8'h00;
    req.first_addr  = 16'h0000;
    req.quantity    = 16'h0000;
    req.payload_len = 6'd0;
    req.data_byte   = 8'h00;
    req.rx_last     = 1'b0;
    rsp.ready       = 1'b0;
    src_idle        = 12;
    sink_idle       = 71;
    stall_left      = 0;
    items_sent      = 0;
    mismatches      = 0;
    tx_seen         = 0;
    for (int i = 0; i < 8; i++) verdict_seen[i] = 0;

    slave_addr = 8'd1;
    held_fc    = 8'h00;
    want_len   = 8'h00;
    pay_count  = 0;
    pay_target = 0;
    pay_open   = 1'b0;
    for (int i = 0; i < 6; i++) echo[i] = 8'h00;
    rx_restart();

    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h01, 1, 1,
                              mrcf_pkg::VERDICT_UNKNOWN));
    script.push_back(make_row(mrcf_pkg::REQ_PAYLOAD, 0, 0, 0, 0, 8'hAA, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(REQ_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F, 8'hFF, 1, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_RD_HOLDING, 0, 0, 0, 0, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h01, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, mrcf_pkg::FC_RD_HOLDING, 1, 1,
                              mrcf_pkg::VERDICT_SHORT));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_RD_COILS, 16'hFFFF, 16'hFFFF,
                              0, 0, 0, 0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h01, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, mrcf_pkg::FC_RD_COILS, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h00, 1, 1,
                              mrcf_pkg::VERDICT_COUNT));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_WR_COIL, 16'h00FF, 1, 0, 0, 0,
                              0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h01, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, mrcf_pkg::FC_WR_COIL, 1, 1,
                              mrcf_pkg::VERDICT_SHORT));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_WR_COILS, 16'h0013, 16'h000A,
                              0, 0, 0, 0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_WR_REGS, 16'h0001, 2, 4, 0, 0,
                              0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_PAYLOAD, 0, 0, 0, 0, 8'h00, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_PAYLOAD, 0, 0, 0, 0, 8'hFF, 1, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_WR_REG, 16'hFF00, 16'h00FF,
                              0, 0, 0, 0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_START, 8'h80, 16'h5555, 16'hAAAA, 0, 0, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_RD_DISCRETE, 16'h1234, 9, 0,
                              0, 0, 0, mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_PAYLOAD, 0, 0, 0, 0, 8'h55, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h01, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h83, 0, 0,
                              mrcf_pkg::VERDICT_OK));
    script.push_back(make_row(mrcf_pkg::REQ_RX, 0, 0, 0, 0, 8'h02, 1, 1,
                              mrcf_pkg::VERDICT_UNKNOWN));
    script.push_back(make_row(mrcf_pkg::REQ_START, mrcf_pkg::FC_RD_INPUT, 16'h8000, 16'h7FFF,
                              6'h3F, 0, 0, 0, mrcf_pkg::VERDICT_OK));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) offer(script[i].it, script[i].pinned, script[i].verdict);

    items_sent = 0;
    set_slave(8'h00);
    run_phase(143);

    src_idle  = 71;
    sink_idle = 12;
    set_slave(8'hFF);
    run_phase(286);

    src_idle  = 0;
    sink_idle = 0;
    set_slave(8'($urandom_range(2, 254)));
    stall_left = 400;
    run_long_reply();
    run_phase(430);

    drain(60);
    $display("Sent %0d request items; checked %0d frame bytes and verdicts ok %0d, count %0d,",
             items_sent, tx_seen, verdict_seen[mrcf_pkg::VERDICT_OK],
             verdict_seen[mrcf_pkg::VERDICT_COUNT]);
    $display("crc %0d, echo %0d, unknown %0d, short %0d over three idle mixes, address 00/FF.",
             verdict_seen[mrcf_pkg::VERDICT_CRC], verdict_seen[mrcf_pkg::VERDICT_ECHO],
             verdict_seen[mrcf_pkg::VERDICT_UNKNOWN], verdict_seen[mrcf_pkg::VERDICT_SHORT]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
